@@ rtl/rvse_pkg.sv @@
`timescale 1ns / 1ps

package rvse_pkg;

    // major opcodes
    localparam logic [6:0] OP_LOAD   = 7'd3;
    localparam logic [6:0] OP_IMM    = 7'd19;
    localparam logic [6:0] OP_REG    = 7'd51;
    localparam logic [6:0] OP_STORE  = 7'd35;
    localparam logic [6:0] OP_BRANCH = 7'd99;
    localparam logic [6:0] OP_JALR   = 7'd103;
    localparam logic [6:0] OP_JAL    = 7'd111;

    // funct3, arithmetic
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // funct3, loads and stores
    localparam logic [2:0] F3_BYTE = 3'd0;
    localparam logic [2:0] F3_HALF = 3'd1;
    localparam logic [2:0] F3_WORD = 3'd2;

    // funct3, branches
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [6:0] F7_BASE = 7'd0;
    localparam logic [6:0] F7_ALT  = 7'd32;

    // configuration register indexes
    localparam int unsigned      CFG_IDX_W      = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STACK_BASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_BASE  = 2'd2;

    localparam logic [31:0] TEXT_BASE_RST  = 32'h0040_0000;
    localparam logic [31:0] STACK_BASE_RST = 32'h7ff0_0000;
    localparam logic [31:0] DATA_BASE_RST  = 32'h1000_0000;

    localparam logic [4:0] REG_SP = 5'd2;

    // execute stage result
    typedef struct packed {
        logic [31:0] npc;
        logic        halted;
        logic        wr;
        logic [4:0]  rd;
        logic [31:0] val;
        logic        is_load;
        logic [2:0]  ld_f3;
        logic        is_store;
        logic [3:0]  st_mask;
        logic [31:0] off;       // byte offset from data_base
        logic [31:0] st_data;
    } t_exec;

    // data store access request
    typedef struct packed {
        logic        rd_en;
        logic        wr_en;
        logic [31:0] off;
        logic [3:0]  mask;
        logic [31:0] data;
    } t_dmem_req;

endpackage

@@ rtl/rvse_ram.sv @@
`timescale 1ns / 1ps

module rvse_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/rvse_alu.sv @@
`timescale 1ns / 1ps

module rvse_alu
    import rvse_pkg::*;
(
    input  logic [31:0] i_instr,
    input  logic [31:0] i_pc,
    input  logic [31:0] i_rs1_val,
    input  logic [31:0] i_rs2_val,
    input  logic [31:0] i_data_base,
    input  logic        i_halted,
    output t_exec       o_res
);

    logic [6:0]  w_op;
    logic [2:0]  w_f3;
    logic [6:0]  w_f7;
    logic [4:0]  w_rd;
    logic [31:0] w_imm_i;
    logic [31:0] w_imm_s;
    logic [31:0] w_imm_b;
    logic [31:0] w_a;
    logic [31:0] w_b;

    logic [31:0] n_npc;
    logic [31:0] n_val;
    logic        n_wr;
    logic        n_bad;
    logic        n_load;
    logic        n_store;
    logic        n_take;
    logic [3:0]  n_mask;
    logic        w_wr;

    assign w_op    = i_instr[6:0];
    assign w_rd    = i_instr[11:7];
    assign w_f3    = i_instr[14:12];
    assign w_f7    = i_instr[31:25];
    assign w_a     = i_rs1_val;
    assign w_b     = i_rs2_val;
    assign w_imm_i = {{20{i_instr[31]}}, i_instr[31:20]};
    assign w_imm_s = {{20{i_instr[31]}}, i_instr[31:25], i_instr[11:7]};
    assign w_imm_b = {{19{i_instr[31]}}, i_instr[31], i_instr[7], i_instr[30:25],
                      i_instr[11:8], 1'b0};

    always_comb begin
        n_npc   = i_pc + 32'd4;
        n_val   = '0;
        n_wr    = 1'b0;
        n_bad   = 1'b0;
        n_load  = 1'b0;
        n_store = 1'b0;
        n_take  = 1'b0;
        n_mask  = '0;

        unique case (w_op) inside
            OP_REG: begin
                unique case (w_f3)
                    F3_ADD: begin
                        if (w_f7 == F7_BASE) begin
                            n_val = w_a + w_b;
                            n_wr  = 1'b1;
                        end else if (w_f7 == F7_ALT) begin
                            n_val = w_a - w_b;
                            n_wr  = 1'b1;
                        end else begin
                            n_bad = 1'b1;
                        end
                    end
                    F3_SLL: begin
                        n_val = w_a << w_b[4:0];
                        n_wr  = (w_f7 == F7_BASE);
                        n_bad = (w_f7 != F7_BASE);
                    end
                    F3_SR: begin
                        n_val = w_a >> w_b[4:0];
                        n_wr  = (w_f7 == F7_BASE);
                        n_bad = (w_f7 != F7_BASE);
                    end
                    F3_OR: begin
                        n_val = w_a | w_b;
                        n_wr  = (w_f7 == F7_BASE);
                        n_bad = (w_f7 != F7_BASE);
                    end
                    F3_AND: begin
                        n_val = w_a & w_b;
                        n_wr  = (w_f7 == F7_BASE);
                        n_bad = (w_f7 != F7_BASE);
                    end
                    default: n_bad = 1'b1;
                endcase
            end
            OP_IMM: begin
                unique case (w_f3) inside
                    F3_ADD: begin
                        n_val = w_a + w_imm_i;
                        n_wr  = 1'b1;
                    end
                    F3_XOR: begin
                        n_val = w_a ^ w_imm_i;
                        n_wr  = 1'b1;
                    end
                    F3_OR: begin
                        n_val = w_a | w_imm_i;
                        n_wr  = 1'b1;
                    end
                    F3_AND: begin
                        n_val = w_a & w_imm_i;
                        n_wr  = 1'b1;
                    end
                    F3_SLL: begin
                        n_val = w_a << i_instr[24:20];
                        n_wr  = (w_f7 == F7_BASE);
                        n_bad = (w_f7 != F7_BASE);
                    end
                    F3_SR: begin
                        // srai retires without effect
                        n_val = w_a >> i_instr[24:20];
                        n_wr  = (w_f7 == F7_BASE);
                        n_bad = (w_f7 != F7_BASE) && (w_f7 != F7_ALT);
                    end
                    F3_SLT, F3_SLTU: ;
                    default: n_bad = 1'b1;
                endcase
            end
            OP_LOAD: begin
                unique case (w_f3)
                    F3_BYTE: n_mask = 4'b0001;
                    F3_HALF: n_mask = 4'b0011;
                    F3_WORD: n_mask = 4'b1111;
                    default: n_bad  = 1'b1;
                endcase
                n_load = !n_bad;
                n_wr   = !n_bad;
            end
            OP_STORE: begin
                unique case (w_f3)
                    F3_BYTE: n_mask = 4'b0001;
                    F3_HALF: n_mask = 4'b0011;
                    F3_WORD: n_mask = 4'b1111;
                    default: n_bad  = 1'b1;
                endcase
                n_store = !n_bad;
            end
            OP_BRANCH: begin
                unique case (w_f3)
                    F3_BEQ:  n_take = (w_a == w_b);
                    F3_BNE:  n_take = (w_a != w_b);
                    F3_BLT:  n_take = ($signed(w_a) < $signed(w_b));
                    F3_BGE:  n_take = !($signed(w_a) < $signed(w_b));
                    F3_BLTU: n_take = (w_a < w_b);
                    F3_BGEU: n_take = (w_a >= w_b);
                    default: n_bad  = 1'b1;
                endcase
                if (n_take) begin
                    n_npc = i_pc + w_imm_b;
                end
            end
            OP_JAL, OP_JALR: ;
            default: n_bad = 1'b1;
        endcase

        // a halted core holds its pc and changes nothing
        if (i_halted) begin
            n_npc   = i_pc;
            n_wr    = 1'b0;
            n_bad   = 1'b0;
            n_load  = 1'b0;
            n_store = 1'b0;
        end
    end

    assign w_wr = n_wr && (w_rd != 5'd0);

    assign o_res.npc      = n_npc;
    assign o_res.halted   = i_halted | n_bad;
    assign o_res.wr       = w_wr;
    assign o_res.rd       = w_wr ? w_rd : 5'd0;
    assign o_res.val      = w_wr ? n_val : 32'd0;
    assign o_res.is_load  = n_load && w_wr;
    assign o_res.ld_f3    = w_f3;
    assign o_res.is_store = n_store;
    assign o_res.st_mask  = n_mask;
    assign o_res.off      = w_a + ((w_op == OP_STORE) ? w_imm_s : w_imm_i) - i_data_base;
    assign o_res.st_data  = w_b;

endmodule

@@ rtl/rvse_dmem.sv @@
`timescale 1ns / 1ps

module rvse_dmem
    import rvse_pkg::*;
#(
    parameter int unsigned DATA_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dmem_req   i_req,
    output logic [31:0] o_word,
    output logic        o_busy
);

    // four byte banks; byte at offset k lives in bank k[1:0], row k>>2
    localparam int unsigned ROWS  = (DATA_BYTES + 3) / 4;
    localparam int unsigned ROW_W = $clog2(ROWS);

    logic             r_busy;
    logic [ROW_W-1:0] r_clr_row;
    logic [1:0]       r_off_lo;
    logic [3:0]       r_in_byte;
    logic [3:0]       w_in_bank;
    logic [3:0]       w_in_byte;
    logic [7:0]       w_q [4];

    // clearing pass after reset, one row of every bank a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_row <= '0;
        end else if (r_busy) begin
            r_clr_row <= r_clr_row + ROW_W'(1);
            if (r_clr_row == ROW_W'(ROWS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    for (genvar j = 0; j < 4; j++) begin : g_bank
        logic [1:0]       w_idx;    // which byte of the access lands here
        logic [31:0]      w_off;
        logic             w_in;
        logic             w_we;
        logic [ROW_W-1:0] w_waddr;
        logic [7:0]       w_wdata;

        assign w_idx   = 2'(j) - i_req.off[1:0];
        assign w_off   = i_req.off + {30'd0, w_idx};
        assign w_in    = (w_off < 32'(DATA_BYTES));
        assign w_we    = r_busy || (i_req.wr_en && i_req.mask[w_idx] && w_in);
        assign w_waddr = r_busy ? r_clr_row : w_off[ROW_W+1:2];
        assign w_wdata = r_busy ? 8'd0 : 8'(i_req.data >> {w_idx, 3'b000});
        assign w_in_bank[j] = w_in;

        rvse_ram #(
            .WIDTH (8),
            .DEPTH (ROWS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_waddr (w_waddr),
            .i_wdata (w_wdata),
            .i_re    (i_req.rd_en),
            .i_raddr (w_off[ROW_W+1:2]),
            .o_rdata (w_q[j])
        );
    end

    always_comb begin
        logic [1:0] v_bank;
        for (int i = 0; i < 4; i++) begin
            v_bank       = i_req.off[1:0] + 2'(i);
            w_in_byte[i] = w_in_bank[v_bank];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_off_lo  <= i_req.off[1:0];
            r_in_byte <= w_in_byte;
        end
    end

    // realign the banks into access order; bytes outside the window read 0
    always_comb begin
        logic [1:0] v_bank;
        for (int i = 0; i < 4; i++) begin
            v_bank           = r_off_lo + 2'(i);
            o_word[8*i +: 8] = r_in_byte[i] ? w_q[v_bank] : 8'd0;
        end
    end

    assign o_busy = r_busy;

endmodule

@@ rtl/rv32i_subset_execute.sv @@
`timescale 1ns / 1ps

// RV32I subset execute block.
// Input channel: one instruction word per i_in_valid/o_in_stall handshake,
// taken as the instruction at the current pc. Output channel: one result
// word per instruction on o_out_valid/i_out_stall (next pc, sticky halt,
// register writeback). Configuration writes use i_cfg_valid/o_cfg_ready,
// always ready; they are meant for idle periods only.
// Accepted instructions go to the execute register, then the result register.
// One instruction per cycle unless stalled. An execute register feeds the
// operand/ALU/branch/address logic, with forwarding from the result stage
// (load data included, straight off the data store banks) and from the
// last retired write, so dependent instructions follow without bubbles.
// Reset: pc, x2 and data window take their default bases, the halt flag
// clears, and the data store is zeroed by a pass over its (DATA_BYTES+3)/4
// rows (1024 at the default size) during which o_in_stall is high.
// When i_out_stall is high a valid result register holds, the execute stage
// holds behind it, and o_in_stall rises once the execute stage is full.
module rv32i_subset_execute
    import rvse_pkg::*;
#(
    parameter int unsigned DATA_BYTES = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [31:0]          i_instr_word,

    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [31:0]          o_next_pc,
    output logic                 o_halted,
    output logic                 o_reg_written,
    output logic [4:0]           o_reg_index,
    output logic [31:0]          o_reg_value,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    // architectural state and configuration
    logic [31:0] r_pc;
    logic        r_halt;
    logic [31:0] r_stack_base;
    logic [31:0] r_data_base;
    logic [31:0] r_gpr_vld;

    // last retired register write
    logic        r_lw_vld;
    logic [4:0]  r_lw_rd;
    logic [31:0] r_lw_val;

    // execute stage
    logic        r_a_vld;
    logic [31:0] r_a_instr;

    // result stage
    logic        r_b_vld;
    logic [31:0] r_b_npc;
    logic        r_b_halt;
    logic        r_b_wr;
    logic [4:0]  r_b_rd;
    logic [31:0] r_b_val;
    logic        r_b_load;
    logic [2:0]  r_b_f3;

    logic        w_cfg_we;
    logic        w_in_acc;
    logic        w_b_adv;
    logic        w_a_move;
    logic        w_retire;
    logic        w_busy;
    logic [31:0] w_q1;
    logic [31:0] w_q2;
    logic [31:0] w_ld_word;
    logic [31:0] w_ld_val;
    logic [31:0] w_b_value;
    logic [31:0] w_rs1_val;
    logic [31:0] w_rs2_val;
    t_exec       w_exec;
    t_dmem_req   w_dreq;

    assign w_cfg_we   = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = 1'b1;

    assign w_b_adv    = !r_b_vld || !i_out_stall;
    assign o_in_stall = w_busy || (r_a_vld && !w_b_adv);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_a_move   = r_a_vld && w_b_adv;
    assign w_retire   = r_b_vld && !i_out_stall;

    // ---------------- register file ----------------

    rvse_ram #(
        .WIDTH (32),
        .DEPTH (32)
    ) u_gpr_a (
        .i_clk   (i_clk),
        .i_we    (w_retire && r_b_wr),
        .i_waddr (r_b_rd),
        .i_wdata (w_b_value),
        .i_re    (w_in_acc),
        .i_raddr (i_instr_word[19:15]),
        .o_rdata (w_q1)
    );

    rvse_ram #(
        .WIDTH (32),
        .DEPTH (32)
    ) u_gpr_b (
        .i_clk   (i_clk),
        .i_we    (w_retire && r_b_wr),
        .i_waddr (r_b_rd),
        .i_wdata (w_b_value),
        .i_re    (w_in_acc),
        .i_raddr (i_instr_word[24:20]),
        .o_rdata (w_q2)
    );

    // operand select: result stage, then last retired write, then the file;
    // entries never written since reset read 0, x2 reads stack_base
    always_comb begin
        logic [4:0] v_rs;
        v_rs = r_a_instr[19:15];
        if (v_rs == 5'd0) begin
            w_rs1_val = '0;
        end else if (r_b_vld && r_b_wr && (r_b_rd == v_rs)) begin
            w_rs1_val = w_b_value;
        end else if (r_lw_vld && (r_lw_rd == v_rs)) begin
            w_rs1_val = r_lw_val;
        end else if (r_gpr_vld[v_rs]) begin
            w_rs1_val = w_q1;
        end else if (v_rs == REG_SP) begin
            w_rs1_val = r_stack_base;
        end else begin
            w_rs1_val = '0;
        end
    end

    always_comb begin
        logic [4:0] v_rs;
        v_rs = r_a_instr[24:20];
        if (v_rs == 5'd0) begin
            w_rs2_val = '0;
        end else if (r_b_vld && r_b_wr && (r_b_rd == v_rs)) begin
            w_rs2_val = w_b_value;
        end else if (r_lw_vld && (r_lw_rd == v_rs)) begin
            w_rs2_val = r_lw_val;
        end else if (r_gpr_vld[v_rs]) begin
            w_rs2_val = w_q2;
        end else if (v_rs == REG_SP) begin
            w_rs2_val = r_stack_base;
        end else begin
            w_rs2_val = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gpr_vld <= '0;
            r_lw_vld  <= 1'b0;
        end else if (w_cfg_we && (i_cfg_index == CFG_STACK_BASE)) begin
            // x2 falls back to the new stack_base
            r_gpr_vld[REG_SP] <= 1'b0;
            r_lw_vld          <= 1'b0;
        end else if (w_retire && r_b_wr) begin
            r_gpr_vld[r_b_rd] <= 1'b1;
            r_lw_vld          <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_retire && r_b_wr) begin
            r_lw_rd  <= r_b_rd;
            r_lw_val <= w_b_value;
        end
    end

    // ---------------- execute ----------------

    rvse_alu u_alu (
        .i_instr     (r_a_instr),
        .i_pc        (r_pc),
        .i_rs1_val   (w_rs1_val),
        .i_rs2_val   (w_rs2_val),
        .i_data_base (r_data_base),
        .i_halted    (r_halt),
        .o_res       (w_exec)
    );

    assign w_dreq.rd_en = w_a_move && w_exec.is_load;
    assign w_dreq.wr_en = w_a_move && w_exec.is_store;
    assign w_dreq.off   = w_exec.off;
    assign w_dreq.mask  = w_exec.st_mask;
    assign w_dreq.data  = w_exec.st_data;

    rvse_dmem #(
        .DATA_BYTES (DATA_BYTES)
    ) u_dmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_word  (w_ld_word),
        .o_busy  (w_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc         <= TEXT_BASE_RST;
            r_halt       <= 1'b0;
            r_stack_base <= STACK_BASE_RST;
            r_data_base  <= DATA_BASE_RST;
        end else if (w_cfg_we) begin
            case (i_cfg_index)
                CFG_TEXT_BASE:  r_pc         <= i_cfg_data;
                CFG_STACK_BASE: r_stack_base <= i_cfg_data;
                CFG_DATA_BASE:  r_data_base  <= i_cfg_data;
                default: ;
            endcase
        end else if (w_a_move) begin
            r_pc   <= w_exec.npc;
            r_halt <= w_exec.halted;
        end
    end

    // ---------------- pipeline registers ----------------

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (w_b_adv || !r_a_vld) begin
                r_a_vld <= w_in_acc;
            end
            if (w_b_adv) begin
                r_b_vld <= r_a_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_a_instr <= i_instr_word;
        end
        if (w_a_move) begin
            r_b_npc  <= w_exec.npc;
            r_b_halt <= w_exec.halted;
            r_b_wr   <= w_exec.wr;
            r_b_rd   <= w_exec.rd;
            r_b_val  <= w_exec.val;
            r_b_load <= w_exec.is_load;
            r_b_f3   <= w_exec.ld_f3;
        end
    end

    // ---------------- result ----------------

    always_comb begin
        case (r_b_f3)
            F3_BYTE: w_ld_val = {{24{w_ld_word[7]}}, w_ld_word[7:0]};
            F3_HALF: w_ld_val = {{16{w_ld_word[15]}}, w_ld_word[15:0]};
            default: w_ld_val = w_ld_word;
        endcase
    end

    assign w_b_value = !r_b_wr ? 32'd0 : (r_b_load ? w_ld_val : r_b_val);

    assign o_out_valid   = r_b_vld;
    assign o_next_pc     = r_b_npc;
    assign o_halted      = r_b_halt;
    assign o_reg_written = r_b_wr;
    assign o_reg_index   = r_b_rd;
    assign o_reg_value   = w_b_value;

endmodule
